@@ src/cdvh_pkg.sv @@
// ----------------------------------------------------------------------------
// Cumulative DVH package
// Shared sizes, operation codes and arithmetic constants for the cumulative
// dose-volume histogram unit and its sub-blocks.
// ----------------------------------------------------------------------------
package cdvh_pkg;

    // Histogram geometry
    localparam int HIST_BINS   = 1024;
    localparam int COUNT_WIDTH = 20;
    localparam int BIN_W       = $clog2(HIST_BINS);

    // Port field widths
    localparam int OP_W      = 2;
    localparam int DOSE_W    = 16;
    localparam int INDEX_W   = 10;
    localparam int VOL_W     = 24;
    localparam int VALUE_W   = 40;
    localparam int VCOUNT_W  = 20;

    // Derived datapath widths
    localparam int PROD_W    = COUNT_WIDTH + VOL_W;   // count times voxel volume
    localparam int PCT_W     = 15;                    // width of the Q.8 percent scale
    localparam int NUM_W     = COUNT_WIDTH + PCT_W;   // dividend of the percent divide
    localparam int DIV_CNT_W = $clog2(NUM_W + 1);

    // 100 percent in Q.8
    localparam logic [PCT_W-1:0] PERCENT_Q8 = PCT_W'(25600);

    // floor(d / 10) = (d * 0xCCCD) >> 19, exact for every 16-bit dose
    localparam logic [DOSE_W-1:0] DIV10_MUL   = 16'hCCCD;
    localparam int                DIV10_SHIFT = 19;
    localparam int                DOSE_PROD_W = 2 * DOSE_W;
    localparam int                DOSE_BIN_W  = DOSE_PROD_W - DIV10_SHIFT;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX  = '1;
    localparam logic [VOL_W-1:0]       VOL_RESET  = VOL_W'(65536);
    localparam logic [63:0]            VALUE_MAX  = 64'((64'd1 << VALUE_W) - 64'd1);
    localparam logic [63:0]            VCOUNT_MAX = 64'((64'd1 << VCOUNT_W) - 64'd1);

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_ADD    = 2'd1,
        OP_FINISH = 2'd2,
        OP_READ   = 2'd3
    } op_t;

endpackage

@@ src/cdvh_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// Simple dual-port synchronous RAM: one write port, one read port with the
// read data registered.
// ----------------------------------------------------------------------------
module cdvh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/cdvh_div.sv @@
// ----------------------------------------------------------------------------
// Percent divider
// Restoring divider producing NUM_W quotient bits, one quotient bit per cycle.
// Pulses done for one cycle with the quotient held until the next start.
// ----------------------------------------------------------------------------
module cdvh_div
    import cdvh_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [NUM_W-1:0]       numer,
    input  logic [COUNT_WIDTH-1:0] denom,
    output logic                   done,
    output logic [NUM_W-1:0]       quot
);

    logic                   run_reg,  run_next;
    logic                   done_reg, done_next;
    logic [DIV_CNT_W-1:0]   cnt_reg,  cnt_next;
    logic [COUNT_WIDTH-1:0] rem_reg,  rem_next;
    logic [NUM_W-1:0]       num_reg,  num_next;
    logic [COUNT_WIDTH-1:0] den_reg,  den_next;

    logic [COUNT_WIDTH:0]   trial;
    logic [COUNT_WIDTH:0]   diff;
    logic                   fits;

    // Trial subtraction of the shifted remainder
    always_comb
    begin
        trial = {rem_reg, num_reg[NUM_W-1]};
        diff  = trial - {1'b0, den_reg};
        fits  = (trial >= {1'b0, den_reg});
    end

    // Advance one quotient bit a cycle
    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = DIV_CNT_W'(NUM_W);
            rem_next = '0;
            num_next = numer;
            den_next = denom;
        end
        else if (run_reg)
        begin
            rem_next = fits ? diff[COUNT_WIDTH-1:0] : trial[COUNT_WIDTH-1:0];
            num_next = {num_reg[NUM_W-2:0], fits};
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        num_reg <= num_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = num_reg;

endmodule

@@ src/cumulative_dose_volume_histogram_unit.sv @@
// ----------------------------------------------------------------------------
// Cumulative dose-volume histogram unit
// Bins voxel doses into 0.1 Gy bins held in RAM, forms the reverse cumulative
// sum into a second RAM, and reads back volume or percent of total.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+------------------------------------
//   command  | start / busy            | op, dose, bin_index, relative
//   result   | done (one-cycle strobe) | value, voxel_count, overflow, summed
//   config   | cfg_valid / cfg_ready   | cfg_data (voxel volume)
//
// The length of add and finish is set by the single read port of the bin RAM,
// that of a relative read by the one-bit-per-cycle divider. A relative read
// with zero total is answered without going busy. After reset the bin RAM is
// zeroed by a sweep over all HIST_BINS bins with busy high. Results cannot be
// stalled; cfg_ready is always high.
// ----------------------------------------------------------------------------
module cumulative_dose_volume_histogram_unit
    import cdvh_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [OP_W-1:0]     op,
    input  logic [DOSE_W-1:0]   dose,
    input  logic [INDEX_W-1:0]  bin_index,
    input  logic                relative,
    output logic                done,
    output logic [VALUE_W-1:0]  value,
    output logic [VCOUNT_W-1:0] voxel_count,
    output logic                overflow,
    output logic                summed,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [VOL_W-1:0]    cfg_data
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_CLEAR  = 9'b000000010,
        S_ADD_RD = 9'b000000100,
        S_ADD_WR = 9'b000001000,
        S_FIN    = 9'b000010000,
        S_RD_RD  = 9'b000100000,
        S_RD_MUL = 9'b001000000,
        S_RD_SAT = 9'b010000000,
        S_RD_DIV = 9'b100000000
    } state_t;

    function automatic logic [VALUE_W-1:0] sat_value(input logic [63:0] x);
        sat_value = (x > VALUE_MAX) ? VALUE_MAX[VALUE_W-1:0] : x[VALUE_W-1:0];
    endfunction

    // Control registers
    state_t                 state_reg,     state_next;
    logic [BIN_W-1:0]       idx_reg,       idx_next;
    logic                   issue_reg,     issue_next;
    logic                   pipe_vld_reg,  pipe_vld_next;
    logic                   clr_emit_reg,  clr_emit_next;
    logic                   div_wait_reg,  div_wait_next;
    logic [COUNT_WIDTH-1:0] total_reg,     total_next;
    logic                   ovf_reg,       ovf_next;
    logic                   summed_reg,    summed_next;
    logic [VOL_W-1:0]       vox_vol_reg,   vox_vol_next;
    logic                   done_reg,      done_next;

    // Payload registers
    logic [BIN_W-1:0]       addr_reg,      addr_next;
    logic [BIN_W-1:0]       pipe_addr_reg, pipe_addr_next;
    logic [COUNT_WIDTH-1:0] run_reg,       run_next;
    logic                   rel_reg,       rel_next;
    logic                   add_ovf_reg,   add_ovf_next;
    logic [PROD_W-1:0]      prod_reg,      prod_next;
    logic [NUM_W-1:0]       num_reg,       num_next;
    logic [VALUE_W-1:0]     value_reg,     value_next;

    // RAM and divider hookup
    logic                   bin_we;
    logic [BIN_W-1:0]       bin_waddr;
    logic [COUNT_WIDTH-1:0] bin_wdata;
    logic [BIN_W-1:0]       bin_raddr;
    logic [COUNT_WIDTH-1:0] bin_rdata;
    logic                   cum_we;
    logic [COUNT_WIDTH-1:0] cum_wdata;
    logic [COUNT_WIDTH-1:0] cum_rdata;
    logic                   div_start;
    logic                   div_done;
    logic [NUM_W-1:0]       div_quot;

    // Decode helpers
    logic                   accept;
    op_t                    op_code;
    logic [DOSE_PROD_W-1:0] dose_prod;
    logic [DOSE_BIN_W-1:0]  dose_q;
    logic                   dose_beyond;
    logic [BIN_W-1:0]       dose_bin;
    logic                   idx_oob;
    logic [COUNT_WIDTH:0]   run_sum;
    logic                   run_sat;

    cdvh_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (HIST_BINS)
    ) u_bin_ram (
        .clk   (clk),
        .we    (bin_we),
        .waddr (bin_waddr),
        .wdata (bin_wdata),
        .raddr (bin_raddr),
        .rdata (bin_rdata)
    );

    cdvh_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (HIST_BINS)
    ) u_cum_ram (
        .clk   (clk),
        .we    (cum_we),
        .waddr (pipe_addr_reg),
        .wdata (cum_wdata),
        .raddr (addr_reg),
        .rdata (cum_rdata)
    );

    cdvh_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (num_reg),
        .denom (total_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Decode the command and bin the dose (divide by 10 via reciprocal)
    always_comb
    begin
        accept      = start && (state_reg == S_IDLE);
        op_code     = op_t'(op);
        dose_prod   = DOSE_PROD_W'(dose) * DOSE_PROD_W'(DIV10_MUL);
        dose_q      = dose_prod[DOSE_PROD_W-1:DIV10_SHIFT];
        dose_beyond = (32'(dose_q) >= 32'(HIST_BINS));
        dose_bin    = dose_beyond ? BIN_W'(HIST_BINS - 1) : BIN_W'(dose_q);
        idx_oob     = (32'(bin_index) >= 32'(HIST_BINS));
        run_sum     = {1'b0, run_reg} + {1'b0, bin_rdata};
        run_sat     = run_sum[COUNT_WIDTH];
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        issue_next     = issue_reg;
        pipe_vld_next  = 1'b0;
        clr_emit_next  = clr_emit_reg;
        div_wait_next  = div_wait_reg;
        total_next     = total_reg;
        ovf_next       = ovf_reg;
        summed_next    = summed_reg;
        vox_vol_next   = vox_vol_reg;
        done_next      = 1'b0;
        addr_next      = addr_reg;
        pipe_addr_next = pipe_addr_reg;
        run_next       = run_reg;
        rel_next       = rel_reg;
        add_ovf_next   = add_ovf_reg;
        prod_next      = prod_reg;
        num_next       = num_reg;
        value_next     = value_reg;
        bin_we         = 1'b0;
        bin_waddr      = addr_reg;
        bin_wdata      = '0;
        bin_raddr      = (state_reg == S_FIN) ? idx_reg : addr_reg;
        cum_we         = 1'b0;
        cum_wdata      = run_sat ? COUNT_MAX : run_sum[COUNT_WIDTH-1:0];
        div_start      = 1'b0;

        // Take the voxel volume whenever written
        if (cfg_valid)
        begin
            vox_vol_next = cfg_data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (op_code)
                        OP_CLEAR:
                        begin
                            idx_next      = '0;
                            clr_emit_next = 1'b1;
                            state_next    = S_CLEAR;
                        end
                        OP_ADD:
                        begin
                            addr_next    = dose_bin;
                            add_ovf_next = dose_beyond;
                            state_next   = S_ADD_RD;
                        end
                        OP_FINISH:
                        begin
                            idx_next   = BIN_W'(HIST_BINS - 1);
                            issue_next = 1'b1;
                            run_next   = '0;
                            state_next = S_FIN;
                        end
                        OP_READ:
                        begin
                            // Answer at once for a relative read with nothing counted
                            if (idx_oob || (relative && (total_reg == '0)))
                            begin
                                value_next = '0;
                                done_next  = 1'b1;
                            end
                            else
                            begin
                                addr_next  = BIN_W'(bin_index);
                                rel_next   = relative;
                                state_next = S_RD_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // Zero one bin a cycle
            S_CLEAR:
            begin
                bin_we    = 1'b1;
                bin_waddr = idx_reg;
                if (idx_reg == BIN_W'(HIST_BINS - 1))
                begin
                    state_next    = S_IDLE;
                    clr_emit_next = 1'b0;
                    if (clr_emit_reg)
                    begin
                        total_next  = '0;
                        ovf_next    = 1'b0;
                        summed_next = 1'b0;
                        value_next  = '0;
                        done_next   = 1'b1;
                    end
                end
                else
                begin
                    idx_next = idx_reg + BIN_W'(1);
                end
            end

            S_ADD_RD:
            begin
                state_next = S_ADD_WR;
            end

            // Increment bin and total, both saturating
            S_ADD_WR:
            begin
                bin_we   = 1'b1;
                ovf_next = ovf_reg || add_ovf_reg;
                if (bin_rdata == COUNT_MAX)
                begin
                    bin_wdata = COUNT_MAX;
                    ovf_next  = 1'b1;
                end
                else
                begin
                    bin_wdata = bin_rdata + COUNT_WIDTH'(1);
                end
                if (total_reg == COUNT_MAX)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    total_next = total_reg + COUNT_WIDTH'(1);
                end
                summed_next = 1'b0;
                value_next  = '0;
                done_next   = 1'b1;
                state_next  = S_IDLE;
            end

            // Walk bins from the top down, one read issued and one sum written a cycle
            S_FIN:
            begin
                if (issue_reg)
                begin
                    if (idx_reg == '0)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        idx_next = idx_reg - BIN_W'(1);
                    end
                end
                pipe_vld_next  = issue_reg;
                pipe_addr_next = idx_reg;
                if (pipe_vld_reg)
                begin
                    cum_we   = 1'b1;
                    run_next = cum_wdata;
                    if (run_sat)
                    begin
                        ovf_next = 1'b1;
                    end
                    if (pipe_addr_reg == '0)
                    begin
                        summed_next = 1'b1;
                        value_next  = '0;
                        done_next   = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
            end

            S_RD_RD:
            begin
                state_next = S_RD_MUL;
            end

            // Scale the cumulative count
            S_RD_MUL:
            begin
                if (rel_reg)
                begin
                    num_next      = NUM_W'(cum_rdata) * NUM_W'(PERCENT_Q8);
                    div_wait_next = 1'b0;
                    state_next    = S_RD_DIV;
                end
                else
                begin
                    prod_next  = PROD_W'(cum_rdata) * PROD_W'(vox_vol_reg);
                    state_next = S_RD_SAT;
                end
            end

            S_RD_SAT:
            begin
                value_next = sat_value(64'(prod_reg));
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            // Launch the divide, then wait for its quotient
            S_RD_DIV:
            begin
                if (!div_wait_reg)
                begin
                    div_start     = 1'b1;
                    div_wait_next = 1'b1;
                end
                else if (div_done)
                begin
                    value_next    = sat_value(64'(div_quot));
                    done_next     = 1'b1;
                    div_wait_next = 1'b0;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state; reset starts the bin RAM clearing sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            idx_reg      <= '0;
            issue_reg    <= 1'b0;
            pipe_vld_reg <= 1'b0;
            clr_emit_reg <= 1'b0;
            div_wait_reg <= 1'b0;
            total_reg    <= '0;
            ovf_reg      <= 1'b0;
            summed_reg   <= 1'b0;
            vox_vol_reg  <= VOL_RESET;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            issue_reg    <= issue_next;
            pipe_vld_reg <= pipe_vld_next;
            clr_emit_reg <= clr_emit_next;
            div_wait_reg <= div_wait_next;
            total_reg    <= total_next;
            ovf_reg      <= ovf_next;
            summed_reg   <= summed_next;
            vox_vol_reg  <= vox_vol_next;
            done_reg     <= done_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        addr_reg      <= addr_next;
        pipe_addr_reg <= pipe_addr_next;
        run_reg       <= run_next;
        rel_reg       <= rel_next;
        add_ovf_reg   <= add_ovf_next;
        prod_reg      <= prod_next;
        num_reg       <= num_next;
        value_reg     <= value_next;
    end

    // Outputs
    assign busy        = (state_reg != S_IDLE);
    assign cfg_ready   = 1'b1;
    assign done        = done_reg;
    assign value       = value_reg;
    assign voxel_count = (64'(total_reg) > VCOUNT_MAX) ? VCOUNT_MAX[VCOUNT_W-1:0]
                                                        : VCOUNT_W'(total_reg);
    assign overflow    = ovf_reg;
    assign summed      = summed_reg;

endmodule

@@ src/cdvh_checker.sv @@
// ----------------------------------------------------------------------------
// Cumulative DVH port checker
// Watches the top-level ports for slips in handshake timing and status
// updates, and is bound to the top level.
// ----------------------------------------------------------------------------
module cdvh_checker
    import cdvh_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                done,
    input logic [VCOUNT_W-1:0] voxel_count,
    input logic                overflow,
    input logic                summed,
    input logic                cfg_valid,
    input logic                cfg_ready
);

    // A result is only shown once the block has gone idle
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
    else $error("result strobe while busy");

    // An accepted item either occupies the block or answers in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
    else $error("accepted item neither started nor answered");

    // Status outputs move only with a result or while an item is in work
    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable({voxel_count, overflow, summed}) |-> (done || busy))
    else $error("status changed while idle");

    // Nothing counted means nothing could have overflowed
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (voxel_count == '0)) |-> !overflow)
    else $error("overflow reported with an empty histogram");

    // Configuration writes are never held off
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind cumulative_dose_volume_histogram_unit cdvh_checker u_cdvh_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .voxel_count (voxel_count),
    .overflow    (overflow),
    .summed      (summed),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready)
);
